[rtl/aes_pkg.sv]
package aes_pkg;

	localparam int NUM_ROUNDS = 10;
	localparam int RK_COUNT = NUM_ROUNDS + 1;

	typedef enum logic [1:0] {
		REG_KEY_HIGH = 2'd0,
		REG_KEY_LOW  = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [63:0] plain_high;
		logic [63:0] plain_low;
	} in_item_t;

	typedef struct packed {
		logic [63:0] cipher_high;
		logic [63:0] cipher_low;
	} out_item_t;

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] tab [256];
		tab = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return tab[x];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	// byte 0 sits in bits 127:120
	function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
		return s[127 - 8*i -: 8];
	endfunction

	// one key-schedule step
	function automatic logic [127:0] next_rk(input logic [127:0] p, input logic [7:0] rc);
		logic [7:0] q [16];
		logic [127:0] r;
		q[0] = sbox(byte_at(p, 13)) ^ rc ^ byte_at(p, 0);
		q[1] = sbox(byte_at(p, 14)) ^ byte_at(p, 1);
		q[2] = sbox(byte_at(p, 15)) ^ byte_at(p, 2);
		q[3] = sbox(byte_at(p, 12)) ^ byte_at(p, 3);
		for (int j = 4; j < 16; j++) q[j] = q[j-4] ^ byte_at(p, j);
		for (int j = 0; j < 16; j++) r[127 - 8*j -: 8] = q[j];
		return r;
	endfunction

	// SubBytes, ShiftRows, optional MixColumns, AddRoundKey
	function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
			input logic mix);
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, al;
		logic [127:0] r;
		for (int c = 0; c < 4; c++)
			for (int k = 0; k < 4; k++)
				t[4*c+k] = sbox(byte_at(s, 4*((c+k)%4)+k));
		if (mix) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
				al = a0 ^ a1 ^ a2 ^ a3;
				t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
				t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
				t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
				t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
			end
		end
		for (int j = 0; j < 16; j++) r[127 - 8*j -: 8] = t[j] ^ byte_at(rk, j);
		return r;
	endfunction

endpackage

[rtl/aes_key_sched.sv]
// Round keys are recomputed from the key registers in a chain of
// registered steps. The user must see that the key only changes while the
// pipeline is idle; the block does not enforce this. Registering each
// round key after its own step keeps each path one S-box deep. Round key
// r is ready before stage r needs it, except in the cycle right after a
// key write, when round key 0 is still old. key_busy covers that cycle.
module aes_key_sched (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	input  logic [1:0] cfg_index,
	input  logic [63:0] cfg_data,
	output logic [aes_pkg::RK_COUNT-1:0][127:0] round_keys,
	output logic key_busy
);
	logic [63:0] key_high_q, key_low_q;
	logic key_busy_q;
	logic [aes_pkg::RK_COUNT-1:0][127:0] rk_q;
	logic [7:0] rc [aes_pkg::RK_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
			key_busy_q <= 1'b1;
		end else begin
			key_busy_q <= cfg_valid;
			if (cfg_valid) begin
				if (cfg_index == aes_pkg::REG_KEY_HIGH) key_high_q <= cfg_data;
				else if (cfg_index == aes_pkg::REG_KEY_LOW) key_low_q <= cfg_data;
			end
		end
	end

	always_comb begin
		rc[0] = 8'h00;
		rc[1] = 8'h01;
		for (int r = 2; r < aes_pkg::RK_COUNT; r++) rc[r] = aes_pkg::xtime(rc[r-1]);
	end

	// chain of registered steps, one per round key
	always_ff @(posedge clk) begin
		rk_q[0] <= {key_high_q, key_low_q};
		for (int r = 1; r < aes_pkg::RK_COUNT; r++)
			rk_q[r] <= aes_pkg::next_rk(rk_q[r-1], rc[r]);
	end

	assign round_keys = rk_q;
	assign key_busy = key_busy_q;
endmodule

[rtl/aes_round_stage.sv]
module aes_round_stage (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  logic in_vld,
	input  logic [127:0] in_state,
	input  logic [127:0] rk,
	input  logic mix,
	output logic out_vld,
	output logic [127:0] out_state
);
	logic vld_s1;
	logic [127:0] state_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (advance) vld_s1 <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (advance) state_s1 <= aes_pkg::aes_round(in_state, rk, mix);
	end

	assign out_vld = vld_s1;
	assign out_state = state_s1;
endmodule

[rtl/aes128_block_encrypt.sv]
// AES-128 block encryptor, fully pipelined.
// Input channel: in_valid/in_stall with an in_item_t payload (plaintext);
// a transaction happens when in_valid is high and in_stall is low.
// Output channel: out_valid/out_stall with an out_item_t payload.
// Config channel: cfg_valid/cfg_ready, cfg_index 0 = key_high, 1 = key_low,
// other indexes are dropped. cfg_ready is always high. Write keys only while
// idle. in_stall stays high for the cycle after a key write. After that,
// blocks may enter at once, because each round key settles before its
// stage needs it.
// The input transaction loads the initial AddRoundKey stage; after it
// comes one register per round, and the last round register drives
// out_valid and out_data. Throughput: one block per cycle while in_stall
// is low.
// The pipeline is a single enable chain: when out_stall is high and the
// output holds a valid block, every stage freezes and in_stall rises.
// Reset clears all valid bits and the key to zero; in_stall is high for the
// first cycle after reset is released.
module aes128_block_encrypt (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  aes_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output aes_pkg::out_item_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [63:0] cfg_data
);
	logic [aes_pkg::RK_COUNT-1:0][127:0] round_keys;
	logic [aes_pkg::RK_COUNT:0] vld;
	logic [aes_pkg::RK_COUNT:0][127:0] st;
	logic advance;
	logic key_busy;
	logic vld_s0;
	logic [127:0] state_s0;

	assign cfg_ready = 1'b1;

	aes_key_sched u_key (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .round_keys(round_keys), .key_busy(key_busy)
	);

	assign advance = !(out_valid && out_stall);
	assign in_stall = !advance || key_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s0 <= 1'b0;
		else if (advance) vld_s0 <= in_valid && !key_busy;
	end

	always_ff @(posedge clk) begin
		if (advance) state_s0 <= {in_data.plain_high, in_data.plain_low} ^ round_keys[0];
	end

	assign vld[0] = vld_s0;
	assign st[0] = state_s0;

	for (genvar r = 1; r < aes_pkg::RK_COUNT; r++) begin : g_round
		aes_round_stage u_rnd (
			.clk(clk), .arst_n(arst_n), .advance(advance),
			.in_vld(vld[r-1]), .in_state(st[r-1]), .rk(round_keys[r]),
			.mix(r < aes_pkg::NUM_ROUNDS),
			.out_vld(vld[r]), .out_state(st[r])
		);
	end

	assign vld[aes_pkg::RK_COUNT] = 1'b0;
	assign st[aes_pkg::RK_COUNT] = '0;

	assign out_valid = vld[aes_pkg::RK_COUNT-1] | vld[aes_pkg::RK_COUNT];
	assign out_data.cipher_high = st[aes_pkg::RK_COUNT-1][127:64] | st[aes_pkg::RK_COUNT][127:64];
	assign out_data.cipher_low = st[aes_pkg::RK_COUNT-1][63:0] | st[aes_pkg::RK_COUNT][63:0];
endmodule

[rtl/aes_checker.sv]
module aes_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input aes_pkg::out_item_t out_data,
	input logic cfg_ready
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out held");
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall) else $error("in_stall low while output held");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready) else $error("cfg_ready low");
	// a block that flows through unstalled shows up after the last round
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall ##1 !in_stall [*aes_pkg::NUM_ROUNDS] |=> out_valid)
		else $error("latency");
endmodule

bind aes128_block_encrypt aes_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data), .cfg_ready(cfg_ready)
);
